// File: hdl/sts_pkg.sv
// -----------------------------------------------------------------------------
// Source token scanner package
// Scanner states, token kinds, character codes and the character class
// functions shared by the scanner core and the top level.
// -----------------------------------------------------------------------------
package sts_pkg;

	// Token length counter width, fixed by the result format.
	localparam int LEN_BITS = 16;

	// Depth of the result queue in front of the token channel.
	localparam int QUEUE_DEPTH = 4;

	// Character codes that the scanner recognises.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_LCUR   = 8'h7B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_RCUR   = 8'h7D;

	// Token classes, numbered densely.
	typedef enum logic [4:0] {
		TK_EOF,
		TK_OP,
		TK_UNDERSCORE,
		TK_COMMA,
		TK_LBRACKET,
		TK_RBRACKET,
		TK_LCURLEY,
		TK_RCURLEY,
		TK_LPAREN,
		TK_RPAREN,
		TK_COLON,
		TK_PIPE,
		TK_IDENT,
		TK_INT,
		TK_FLOAT,
		TK_COMMENT,
		TK_BYTE,
		TK_STRING,
		TK_ARROW,
		TK_LOGIC,
		TK_DOT,
		TK_TRIPLE,
		TK_ERROR
	} kind_t;

	// Lexical states.
	typedef enum logic [4:0] {
		ST_START,
		ST_IDENT,
		ST_INT,
		ST_FLOAT,
		ST_SLASH,
		ST_LCOMMENT,
		ST_BLOCK,
		ST_BLOCK_STAR,
		ST_BYTE,
		ST_STRING,
		ST_STRING_ESC,
		ST_MINUS,
		ST_EQ,
		ST_BANG,
		ST_STAR,
		ST_LESS,
		ST_GREATER,
		ST_DOT1,
		ST_DOT2
	} scan_state_t;

	// Decision taken for one character in the start state.
	typedef struct packed {
		scan_state_t next_state;
		logic        imm;
		kind_t       kind;
	} start_dec_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Start-state decode: either a single-character token or the state that
	// begins a longer token. Unknown characters leave the scanner in place.
	function automatic start_dec_t start_decode(input logic [7:0] c);
		start_dec_t d;
		d.next_state = ST_START;
		d.imm        = 1'b0;
		d.kind       = TK_EOF;
		if (is_alpha(c)) begin
			d.next_state = ST_IDENT;
		end else if (is_digit(c)) begin
			d.next_state = ST_INT;
		end else begin
			case (c)
				CH_PLUS, CH_PCT: begin d.imm = 1'b1; d.kind = TK_OP; end
				CH_UNDER:  begin d.imm = 1'b1; d.kind = TK_UNDERSCORE; end
				CH_COMMA:  begin d.imm = 1'b1; d.kind = TK_COMMA; end
				CH_LBRK:   begin d.imm = 1'b1; d.kind = TK_LBRACKET; end
				CH_RBRK:   begin d.imm = 1'b1; d.kind = TK_RBRACKET; end
				CH_LCUR:   begin d.imm = 1'b1; d.kind = TK_LCURLEY; end
				CH_RCUR:   begin d.imm = 1'b1; d.kind = TK_RCURLEY; end
				CH_LPAR:   begin d.imm = 1'b1; d.kind = TK_LPAREN; end
				CH_RPAR:   begin d.imm = 1'b1; d.kind = TK_RPAREN; end
				CH_COLON:  begin d.imm = 1'b1; d.kind = TK_COLON; end
				CH_PIPE:   begin d.imm = 1'b1; d.kind = TK_PIPE; end
				CH_SEMI:   begin d.imm = 1'b1; d.kind = TK_ERROR; end
				CH_SLASH:  d.next_state = ST_SLASH;
				CH_QUOTE:  d.next_state = ST_BYTE;
				CH_DQUOTE: d.next_state = ST_STRING;
				CH_MINUS:  d.next_state = ST_MINUS;
				CH_EQ:     d.next_state = ST_EQ;
				CH_BANG:   d.next_state = ST_BANG;
				CH_STAR:   d.next_state = ST_STAR;
				CH_LT:     d.next_state = ST_LESS;
				CH_GT:     d.next_state = ST_GREATER;
				CH_DOT:    d.next_state = ST_DOT1;
				default:   d.next_state = ST_START;
			endcase
		end
		return d;
	endfunction

endpackage

// File: hdl/sts_fifo.sv
// -----------------------------------------------------------------------------
// Token result queue
// Small queue that takes up to two tokens a cycle and hands out one a cycle
// on a valid/stall channel. Reports when room for two more tokens remains.
// -----------------------------------------------------------------------------
module sts_fifo #(
	parameter int WIDTH = 74
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  logic [WIDTH-1:0] push_data0,
	input  logic [WIDTH-1:0] push_data1,
	output logic             room,
	output logic             head_valid,
	input  logic             head_stall,
	output logic [WIDTH-1:0] head_data
);

	localparam int QD = sts_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(QD);

	logic [WIDTH-1:0] mem [QD];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             pop;

	assign head_valid = (cnt_q != '0);
	assign head_data  = mem[rd_q];
	assign pop        = head_valid & ~head_stall;
	assign room       = (cnt_q <= (PW+1)'(QD - 2));

	// Storage: the first token goes to the write pointer, a second one after it.
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem[wr_q] <= push_data0;
		end
		if (push_count == 2'd2) begin
			mem[PW'(wr_q + 1'b1)] <= push_data1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PW'(wr_q + PW'(push_count));
			rd_q  <= PW'(rd_q + PW'(pop));
			cnt_q <= (PW+1)'(cnt_q + (PW+1)'(push_count) - (PW+1)'(pop));
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QD))
		else $error("token queue fill level beyond its depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(wr_q - rd_q) == cnt_q[PW-1:0])
		else $error("token queue pointers disagree with fill level");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_count == 2'd2) |-> (cnt_q <= (PW+1)'(QD - 2)))
		else $error("two tokens pushed without room for both");

endmodule

// File: hdl/sts_core.sv
// -----------------------------------------------------------------------------
// Source token scanner core
// Lexical state machine with line, column and kept-length counters. Each step
// consumes one character and yields zero, one or two tokens.
// -----------------------------------------------------------------------------
module sts_core #(
	parameter int LINE_BITS   = 24,
	parameter int COLUMN_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output logic [1:0] push_count,
	output logic [5+LINE_BITS+COLUMN_BITS+sts_pkg::LEN_BITS:0] tok0,
	output logic [5+LINE_BITS+COLUMN_BITS+sts_pkg::LEN_BITS:0] tok1
);

	localparam int LB = sts_pkg::LEN_BITS;

	sts_pkg::scan_state_t state_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [LB-1:0]          kept_q;

	sts_pkg::scan_state_t nxt;
	logic                 imm;
	logic                 put;
	sts_pkg::kind_t       dec_kind;
	sts_pkg::start_dec_t  sd;

	sts_pkg::scan_state_t   state_n;
	logic [LB-1:0]          kept_n;
	logic [LINE_BITS-1:0]   line_n;
	logic [COLUMN_BITS-1:0] col_n;
	logic [LB-1:0]          kept_inc;
	logic [LB-1:0]          len0;
	logic [LB-1:0]          len1;
	sts_pkg::kind_t         k0;
	sts_pkg::kind_t         k1;
	logic                   last0;
	logic                   eof;
	logic                   space;

	assign sd    = sts_pkg::start_decode(char_code);
	assign eof   = end_of_input | (char_code == sts_pkg::CH_NUL);
	assign space = sts_pkg::is_space(char_code);

	// Next-state decode: a state change, a token that takes this character
	// (imm) or a token ended by lookahead that leaves it for a rescan (put).
	always_comb begin
		nxt      = state_q;
		imm      = 1'b0;
		put      = 1'b0;
		dec_kind = sts_pkg::TK_EOF;
		case (state_q)
			sts_pkg::ST_START: begin
				nxt      = sd.next_state;
				imm      = sd.imm;
				dec_kind = sd.kind;
			end
			sts_pkg::ST_IDENT: begin
				if (!sts_pkg::is_alpha(char_code) && !sts_pkg::is_digit(char_code) &&
					(char_code != sts_pkg::CH_UNDER)) begin
					put = 1'b1; dec_kind = sts_pkg::TK_IDENT;
				end
			end
			sts_pkg::ST_INT: begin
				if (char_code == sts_pkg::CH_DOT) begin
					nxt = sts_pkg::ST_FLOAT;
				end else if (!sts_pkg::is_digit(char_code)) begin
					put = 1'b1; dec_kind = sts_pkg::TK_INT;
				end
			end
			sts_pkg::ST_FLOAT: begin
				if (!sts_pkg::is_digit(char_code)) begin
					put = 1'b1; dec_kind = sts_pkg::TK_FLOAT;
				end
			end
			sts_pkg::ST_SLASH: begin
				if (char_code == sts_pkg::CH_SLASH) begin
					nxt = sts_pkg::ST_LCOMMENT;
				end else if (char_code == sts_pkg::CH_STAR) begin
					nxt = sts_pkg::ST_BLOCK;
				end else begin
					put = 1'b1; dec_kind = sts_pkg::TK_OP;
				end
			end
			sts_pkg::ST_LCOMMENT: begin
				if (char_code == sts_pkg::CH_NL) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_COMMENT;
				end
			end
			sts_pkg::ST_BLOCK: begin
				if (char_code == sts_pkg::CH_STAR) begin
					nxt = sts_pkg::ST_BLOCK_STAR;
				end
			end
			sts_pkg::ST_BLOCK_STAR: begin
				if (char_code == sts_pkg::CH_SLASH) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_COMMENT;
				end else if (char_code != sts_pkg::CH_STAR) begin
					nxt = sts_pkg::ST_BLOCK;
				end
			end
			sts_pkg::ST_BYTE: begin
				if (char_code == sts_pkg::CH_QUOTE) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_BYTE;
				end
			end
			sts_pkg::ST_STRING: begin
				if (char_code == sts_pkg::CH_BSLASH) begin
					nxt = sts_pkg::ST_STRING_ESC;
				end else if (char_code == sts_pkg::CH_DQUOTE) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_STRING;
				end
			end
			sts_pkg::ST_STRING_ESC: begin
				nxt = sts_pkg::ST_STRING;
			end
			sts_pkg::ST_MINUS: begin
				if (char_code == sts_pkg::CH_GT) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_ARROW;
				end else begin
					put = 1'b1; dec_kind = sts_pkg::TK_OP;
				end
			end
			sts_pkg::ST_EQ: begin
				if (char_code == sts_pkg::CH_EQ) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_LOGIC;
				end else begin
					put = 1'b1; dec_kind = sts_pkg::TK_OP;
				end
			end
			sts_pkg::ST_BANG, sts_pkg::ST_GREATER: begin
				dec_kind = sts_pkg::TK_LOGIC;
				if (char_code == sts_pkg::CH_EQ) begin
					imm = 1'b1;
				end else begin
					put = 1'b1;
				end
			end
			sts_pkg::ST_STAR: begin
				dec_kind = sts_pkg::TK_OP;
				if (char_code == sts_pkg::CH_STAR) begin
					imm = 1'b1;
				end else begin
					put = 1'b1;
				end
			end
			sts_pkg::ST_LESS: begin
				if (char_code == sts_pkg::CH_EQ) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_LOGIC;
				end else if (char_code == sts_pkg::CH_MINUS) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_ARROW;
				end else begin
					put = 1'b1; dec_kind = sts_pkg::TK_LOGIC;
				end
			end
			sts_pkg::ST_DOT1: begin
				if (char_code == sts_pkg::CH_DOT) begin
					nxt = sts_pkg::ST_DOT2;
				end else begin
					put = 1'b1; dec_kind = sts_pkg::TK_DOT;
				end
			end
			sts_pkg::ST_DOT2: begin
				if (char_code == sts_pkg::CH_DOT) begin
					imm = 1'b1; dec_kind = sts_pkg::TK_TRIPLE;
				end else begin
					put = 1'b1; dec_kind = sts_pkg::TK_ERROR;
				end
			end
			default: begin
				nxt = sts_pkg::ST_START;
			end
		endcase
	end

	// Outputs and counter updates. A lookahead token rescans the character
	// from the start state with an empty length count.
	always_comb begin
		kept_inc = (!space && (kept_q != '1)) ? LB'(kept_q + 1'b1) : kept_q;
		len1     = LB'(!space);
		line_n   = line_q;
		col_n    = col_q;
		state_n  = nxt;
		kept_n   = kept_inc;
		k0       = dec_kind;
		k1       = sd.kind;
		len0     = kept_inc;
		last0    = 1'b1;
		push_count = 2'd0;
		if (eof) begin
			state_n    = sts_pkg::ST_START;
			kept_n     = '0;
			k0         = sts_pkg::TK_EOF;
			len0       = kept_q;
			push_count = 2'd1;
		end else begin
			if (char_code == sts_pkg::CH_NL) begin
				line_n = (&line_q) ? line_q : LINE_BITS'(line_q + 1'b1);
				col_n  = COLUMN_BITS'(1);
			end else begin
				col_n  = (&col_q) ? col_q : COLUMN_BITS'(col_q + 1'b1);
			end
			if (imm) begin
				state_n    = sts_pkg::ST_START;
				kept_n     = '0;
				push_count = 2'd1;
			end else if (put) begin
				len0 = kept_q;
				if (sd.imm) begin
					state_n    = sts_pkg::ST_START;
					kept_n     = '0;
					last0      = 1'b0;
					push_count = 2'd2;
				end else begin
					state_n    = sd.next_state;
					kept_n     = len1;
					push_count = 2'd1;
				end
			end
		end
		if (!step) begin
			push_count = 2'd0;
		end
	end

	assign tok0 = {k0, line_n, col_n, len0, last0};
	assign tok1 = {k1, line_n, col_n, len1, 1'b1};

	// Scanner state and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::ST_START;
			line_q  <= '0;
			col_q   <= '0;
			kept_q  <= '0;
		end else if (step) begin
			state_q <= state_n;
			line_q  <= line_n;
			col_q   <= col_n;
			kept_q  <= kept_n;
		end
	end

	a_idle_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		!step |-> (push_count == 2'd0))
		else $error("token pushed without a scanner step");

	a_eof_single: assert property (@(posedge clk) disable iff (!arst_n)
		(step && eof) |-> (push_count == 2'd1) && (k0 == sts_pkg::TK_EOF))
		else $error("end of input must give exactly one end token");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push_count == 2'd2) |-> (!tok0[0] && tok1[0] && put))
		else $error("token pair must come from a lookahead with the second last");

endmodule

// File: hdl/source_token_scanner_unit.sv
// -----------------------------------------------------------------------------
// Source token scanner unit
// Tokenises a source byte stream: one character per request in, one token
// per request out, with kind, line, column and kept length.
// -----------------------------------------------------------------------------
// Usage:
//   The source channel (src_valid, src_stall, char_code, end_of_input) takes
//   one character per cycle. A zero byte or end_of_input ends the input and
//   gives one end token; the scanner then starts afresh with its position kept.
//   The token channel (tok_valid, tok_stall) delivers one token per cycle.
//   A character yields no token, one token, or two when it ends a token by
//   lookahead and then forms a single-character token itself; last_of_run
//   marks the final token of each character.
//   A character accepted on the source channel waits in the input register
//   until the queue has room; the scanner step then writes its tokens into
//   the result queue, whose head is offered on the token channel.
//   Throughput: one character per cycle, limited by the token channel at one
//   token per cycle; src_stall rises while the four-entry result queue has
//   fewer than two free entries and a character waits in the input register.
//   When tok_stall is high the head token holds steady and the queue fills.
//   Reset (arst_n low) empties both stages and clears state, line, column and
//   length counts at once.
// -----------------------------------------------------------------------------
module source_token_scanner_unit #(
	parameter int LINE_BITS   = 24,
	parameter int COLUMN_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  logic [7:0]             char_code,
	input  logic                   end_of_input,
	output logic                   tok_valid,
	input  logic                   tok_stall,
	output logic [4:0]             token_kind,
	output logic [LINE_BITS-1:0]   token_line,
	output logic [COLUMN_BITS-1:0] token_column,
	output logic [15:0]            token_length,
	output logic                   last_of_run
);

	localparam int LB    = sts_pkg::LEN_BITS;
	localparam int TOK_W = 6 + LINE_BITS + COLUMN_BITS + LB;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eof_s1;
	logic             room;
	logic             step;
	logic             accept;
	logic [1:0]       push_count;
	logic [TOK_W-1:0] tok0;
	logic [TOK_W-1:0] tok1;
	logic [TOK_W-1:0] head;

	// The input register advances whenever the queue can absorb two tokens.
	assign step      = valid_s1 & room;
	assign src_stall = valid_s1 & ~room;
	assign accept    = src_valid & ~src_stall;

	// Input register: validity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_code;
			eof_s1  <= end_of_input;
		end
	end

	sts_core #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.char_code    (char_s1),
		.end_of_input (eof_s1),
		.push_count   (push_count),
		.tok0         (tok0),
		.tok1         (tok1)
	);

	sts_fifo #(
		.WIDTH (TOK_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push_data0 (tok0),
		.push_data1 (tok1),
		.room       (room),
		.head_valid (tok_valid),
		.head_stall (tok_stall),
		.head_data  (head)
	);

	// Unpack the head token onto the result ports.
	assign token_kind   = head[TOK_W-1 -: 5];
	assign token_line   = head[TOK_W-6 -: LINE_BITS];
	assign token_column = head[TOK_W-6-LINE_BITS -: COLUMN_BITS];
	assign token_length = head[LB:1];
	assign last_of_run  = head[0];

endmodule
